// ----- rtl/ccst_pkg.sv -----
// Shared types, constants and helpers for the conveyor color sort tracker.
package ccst_pkg;

  localparam int unsigned QueueDepthDef = 10;
  localparam int unsigned CfgIdxW       = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_HOLDOFF  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCAN_WIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DROP     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CLEAR    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MINCLR   = 3'd5;

  // Color codes
  localparam logic [1:0] COL_NONE  = 2'd0;
  localparam logic [1:0] COL_RED   = 2'd1;
  localparam logic [1:0] COL_GREEN = 2'd2;
  localparam logic [1:0] COL_BLUE  = 2'd3;

  // Gate positions
  localparam logic [1:0] GATE_CATCH = 2'd0;
  localparam logic [1:0] GATE_IDLE  = 2'd1;
  localparam logic [1:0] GATE_DROP  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;      // latch inputs, advance tick, entry/scan timing
    logic div_start;  // start normalizing one channel
    logic [1:0] div_sel;  // 0 red, 1 green, 2 blue
    logic classify;   // classify and push
    logic bin_start;  // start bin edge processing for bin_sel
    logic [1:0] bin_sel;
    logic scan_step;  // process one queue entry (index) for current scan
    logic shift_step; // move entry idx+1 into idx
    logic shift_done; // finish removal
    logic gate_tmo;   // drop gate timeouts
    logic want_clr;   // clear want bits
    logic publish;    // load output register
  } ccst_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic bin_edge;   // falling edge on bin_sel
    logic hit;        // entry at idx matched current search
    logic match;      // entry at idx has the color of bin_sel
    logic last;       // idx is last valid entry
    logic empty;      // no entries
  } ccst_sts_t;

  function automatic logic is_past(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] d;
    d = now - dl;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// ----- rtl/conveyor_color_sort_tracker_top.sv -----
// Per request: three divider passes (red, green, blue), then classify and push,
// queue walks for bins, the end clear search, gate timeouts and the want walk.
// Throughput: one request at a time, the next taken the cycle after the result is loaded,
// also while that result waits in the result register.
// Reset (rst_n low, synchronous) clears timers, counts and totals and loads
// register defaults; queue contents are left as they are.
module conveyor_color_sort_tracker_top #(
  parameter int unsigned QUEUE_DEPTH = ccst_pkg::QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_entry_beam,
  input  logic        in_red_beam,
  input  logic        in_green_beam,
  input  logic        in_blue_beam,
  input  logic [15:0] in_raw_red,
  input  logic [15:0] in_raw_green,
  input  logic [15:0] in_raw_blue,
  input  logic [15:0] in_raw_clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_red_gate,
  output logic [1:0]  out_green_gate,
  output logic [1:0]  out_blue_gate,
  output logic        out_belt_on,
  output logic        out_scanning,
  output logic [3:0]  out_boxes_tracked,
  output logic [15:0] out_red_total,
  output logic [15:0] out_green_total,
  output logic [15:0] out_blue_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ccst_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import ccst_pkg::*;

  ccst_cmd_t cmd;
  ccst_sts_t sts;
  logic idx_clr, idx_inc;
  logic [1:0] mode;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] idx;

  assign cfg_ready = 1'b1;

  ccst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts),
    .idx_clr(idx_clr), .idx_inc(idx_inc), .mode(mode)
  );

  ccst_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .sts(sts), .idx_o(idx),
    .idx_clr(idx_clr), .idx_inc(idx_inc), .mode(mode),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_entry_beam(in_entry_beam), .in_red_beam(in_red_beam),
    .in_green_beam(in_green_beam), .in_blue_beam(in_blue_beam),
    .in_raw_red(in_raw_red), .in_raw_green(in_raw_green),
    .in_raw_blue(in_raw_blue), .in_raw_clear(in_raw_clear),
    .out_red_gate(out_red_gate), .out_green_gate(out_green_gate),
    .out_blue_gate(out_blue_gate), .out_belt_on(out_belt_on),
    .out_scanning(out_scanning), .out_boxes_tracked(out_boxes_tracked),
    .out_red_total(out_red_total), .out_green_total(out_green_total),
    .out_blue_total(out_blue_total)
  );

`ifndef SYNTHESIS
  // queue index never runs past the depth
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) else $error("queue index out of range");
  // a tracked count never exceeds the depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_boxes_tracked <= 4'(QUEUE_DEPTH)) else $error("queue overfilled");
  // no new request is taken while busy with one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("request taken while busy");
`endif
endmodule

// ----- rtl/ccst_div.sv -----
// Restoring divider, one quotient bit per cycle: (raw*255)/clear.
module ccst_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [23:0] quot
);
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] trial;

  assign busy = (cnt_r != 5'd0);
  assign quot = q_r;
  assign trial = {rem_r[15:0], q_r[23]};

  // shift-subtract step
  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = 5'd24;
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - 5'd1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt   = {q_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end
endmodule

// ----- rtl/ccst_dp.sv -----
// Datapath: timers, configuration, box queue, gates, totals and result register.
module ccst_dp #(
  parameter int unsigned QUEUE_DEPTH = ccst_pkg::QueueDepthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccst_pkg::ccst_cmd_t   cmd,
  output ccst_pkg::ccst_sts_t   sts,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] idx_o,
  input  logic                  idx_clr,
  input  logic                  idx_inc,
  input  logic [1:0]            mode,     // 0 bin search, 1 end clear search, 2 want
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_idx,
  input  logic [15:0]           cfg_data,
  input  logic                  in_entry_beam,
  input  logic                  in_red_beam,
  input  logic                  in_green_beam,
  input  logic                  in_blue_beam,
  input  logic [15:0]           in_raw_red,
  input  logic [15:0]           in_raw_green,
  input  logic [15:0]           in_raw_blue,
  input  logic [15:0]           in_raw_clear,
  output logic [1:0]            out_red_gate,
  output logic [1:0]            out_green_gate,
  output logic [1:0]            out_blue_gate,
  output logic                  out_belt_on,
  output logic                  out_scanning,
  output logic [3:0]            out_boxes_tracked,
  output logic [15:0]           out_red_total,
  output logic [15:0]           out_green_total,
  output logic [15:0]           out_blue_total
);
  import ccst_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH+1);
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // configuration
  logic [15:0] holdoff_r, scanwin_r, sample_r, drophold_r, endclr_r, minclr_r;
  // timing state
  logic [31:0] now_r, last_entry_r, scan_dl_r, last_sample_r;
  logic        scan_open_r, sample_now_r;
  // latched input
  logic [2:0]  beam_r, prev_beam_r;
  logic [15:0] rr_r, rg_r, rb_r, rc_r;
  // queue
  logic [1:0]  q_color_r [QUEUE_DEPTH];
  logic [1:0]  q_zone_r  [QUEUE_DEPTH];
  logic [31:0] q_dl_r    [QUEUE_DEPTH];
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] idx_r;
  // gates and totals
  logic [2:0]  drop_r;
  logic [31:0] drop_dl_r [3];
  logic [15:0] tot_r [3];
  logic [2:0]  want_r;
  // normalized channels
  logic [23:0] nr_r, ng_r, nb_r;
  logic        div_busy;
  logic [23:0] div_q, div_dvd;
  logic [1:0]  div_sel_r;
  logic        div_busy_d_r;

  logic [IdxW-1:0] ix, ix1;
  logic [1:0]  ent_col, ent_zone;
  logic [31:0] ent_dl;
  logic [1:0]  col;

  assign idx_o = idx_r;
  assign ix  = idx_r[IdxW-1:0];
  assign ix1 = IdxW'(idx_r + CntW'(1));
  assign ent_col  = q_color_r[ix];
  assign ent_zone = q_zone_r[ix];
  assign ent_dl   = q_dl_r[ix];

  // divider operand select from the latched request
  always_comb begin
    case (cmd.div_sel)
      2'd0:    div_dvd = {8'd0, rr_r};
      2'd1:    div_dvd = {8'd0, rg_r};
      default: div_dvd = {8'd0, rb_r};
    endcase
    div_dvd = (div_dvd << 8) - div_dvd;
  end

  ccst_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_dvd),
    .divisor (rc_r),
    .busy    (div_busy),
    .quot    (div_q)
  );

  // classification from normalized channels
  always_comb begin
    logic [23:0] r, g, b;
    r = (rc_r == 16'd0) ? 24'd0 : nr_r;
    g = (rc_r == 16'd0) ? 24'd0 : ng_r;
    b = (rc_r == 16'd0) ? 24'd0 : nb_r;
    col = COL_NONE;
    if (rc_r < minclr_r) col = COL_NONE;
    else if (r >= 24'd170 && g <= 24'd50 && b <= 24'd50) col = COL_RED;
    else if (g > r && g >= 24'd105 && b <= 24'd48) col = COL_GREEN;
    else if (r <= 24'd62 && b > r && (b - r) >= 24'd35 && g > r) col = COL_BLUE;
  end

  // status toward controller
  always_comb begin
    sts.div_busy = div_busy;
    sts.bin_edge = !beam_r[cmd.bin_sel] && prev_beam_r[cmd.bin_sel];
    sts.empty    = (count_r == '0);
    sts.last     = (idx_r + CntW'(1) >= count_r);
    sts.match    = (ent_col == cmd.bin_sel + 2'd1);
    case (mode)
      2'd0:    sts.hit = (ent_zone == cmd.bin_sel);
      2'd1:    sts.hit = (ent_zone == 2'd3) && is_past(now_r, ent_dl);
      default: sts.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= 16'd2000; scanwin_r <= 16'd1500; sample_r <= 16'd50;
      drophold_r <= 16'd1000; endclr_r <= 16'd8000; minclr_r <= 16'd280;
      now_r <= '0; last_entry_r <= '0; scan_dl_r <= '0; last_sample_r <= '0;
      scan_open_r <= 1'b0; sample_now_r <= 1'b0;
      prev_beam_r <= 3'b111; beam_r <= 3'b111;
      count_r <= '0; idx_r <= '0;
      drop_r <= '0; want_r <= '0;
      for (int k = 0; k < 3; k++) begin
        drop_dl_r[k] <= '0;
        tot_r[k] <= '0;
      end
      out_red_gate <= GATE_IDLE; out_green_gate <= GATE_IDLE; out_blue_gate <= GATE_IDLE;
      out_belt_on <= 1'b0; out_scanning <= 1'b0; out_boxes_tracked <= '0;
      out_red_total <= '0; out_green_total <= '0; out_blue_total <= '0;
      div_sel_r <= '0; div_busy_d_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_HOLDOFF:  holdoff_r  <= cfg_data;
          REG_SCAN_WIN: scanwin_r  <= cfg_data;
          REG_SAMPLE:   sample_r   <= cfg_data;
          REG_DROP:     drophold_r <= cfg_data;
          REG_CLEAR:    endclr_r   <= cfg_data;
          REG_MINCLR:   minclr_r   <= cfg_data;
          default: ;
        endcase
      end
      // index counter
      if (idx_clr) idx_r <= '0;
      else if (idx_inc) idx_r <= idx_r + CntW'(1);
      // capture quotient at divider finish
      div_busy_d_r <= div_busy;
      if (cmd.div_start) div_sel_r <= cmd.div_sel;
      if (div_busy_d_r && !div_busy) begin
        case (div_sel_r)
          2'd0:    nr_r <= div_q;
          2'd1:    ng_r <= div_q;
          default: nb_r <= div_q;
        endcase
      end
      // tick start: entry and sample timing
      if (cmd.start) begin
        logic [31:0] n;
        logic        so;
        n  = now_r + 32'd1;
        so = scan_open_r;
        now_r <= n;
        beam_r <= {in_blue_beam, in_green_beam, in_red_beam};
        rr_r <= in_raw_red; rg_r <= in_raw_green; rb_r <= in_raw_blue;
        rc_r <= in_raw_clear;
        if (!in_entry_beam && (n - last_entry_r) > {16'd0, holdoff_r}) begin
          last_entry_r <= n;
          so = 1'b1;
          scan_dl_r <= n + {16'd0, scanwin_r};
        end
        scan_open_r <= so;
        sample_now_r <= so && ((n - last_sample_r) > {16'd0, sample_r});
        if (so && ((n - last_sample_r) > {16'd0, sample_r})) last_sample_r <= n;
      end
      // classify and push, then scan timeout
      if (cmd.classify) begin
        logic so;
        so = scan_open_r;
        if (sample_now_r && col != COL_NONE && count_r < CntW'(QUEUE_DEPTH)) begin
          q_color_r[count_r[IdxW-1:0]] <= col;
          q_zone_r[count_r[IdxW-1:0]]  <= 2'd0;
          q_dl_r[count_r[IdxW-1:0]]    <= '0;
          count_r <= count_r + CntW'(1);
          so = 1'b0;
        end
        if (so && is_past(now_r, scan_dl_r)) so = 1'b0;
        scan_open_r <= so;
      end
      // bin hit on entry idx: drop or advance
      if (cmd.scan_step && mode == 2'd0) begin
        if (ent_col == cmd.bin_sel + 2'd1) begin
          if (tot_r[cmd.bin_sel] != 16'hFFFF) tot_r[cmd.bin_sel] <= tot_r[cmd.bin_sel] + 16'd1;
          drop_r[cmd.bin_sel] <= 1'b1;
          drop_dl_r[cmd.bin_sel] <= now_r + {16'd0, drophold_r};
        end else begin
          q_zone_r[ix] <= cmd.bin_sel + 2'd1;
          if (cmd.bin_sel == 2'd2) q_dl_r[ix] <= now_r + {16'd0, endclr_r};
        end
      end
      // want accumulation over entries
      if (cmd.want_clr) want_r <= '0;
      if (cmd.scan_step && mode == 2'd2) begin
        for (int k = 0; k < 3; k++)
          if (ent_zone <= 2'(k) && ent_col == 2'(k + 1)) want_r[k] <= 1'b1;
      end
      // compaction step
      if (cmd.shift_step) begin
        q_color_r[ix] <= q_color_r[ix1];
        q_zone_r[ix]  <= q_zone_r[ix1];
        q_dl_r[ix]    <= q_dl_r[ix1];
      end
      if (cmd.shift_done) count_r <= count_r - CntW'(1);
      if (cmd.gate_tmo) begin
        for (int k = 0; k < 3; k++)
          if (drop_r[k] && is_past(now_r, drop_dl_r[k])) drop_r[k] <= 1'b0;
      end
      // result register
      if (cmd.publish) begin
        prev_beam_r <= beam_r;
        out_red_gate   <= drop_r[0] ? GATE_DROP : (want_r[0] ? GATE_CATCH : GATE_IDLE);
        out_green_gate <= drop_r[1] ? GATE_DROP : (want_r[1] ? GATE_CATCH : GATE_IDLE);
        out_blue_gate  <= drop_r[2] ? GATE_DROP : (want_r[2] ? GATE_CATCH : GATE_IDLE);
        out_belt_on    <= !scan_open_r && (count_r != '0);
        out_scanning   <= scan_open_r;
        out_boxes_tracked <= 4'(count_r);
        out_red_total   <= tot_r[0];
        out_green_total <= tot_r[1];
        out_blue_total  <= tot_r[2];
      end
    end
  end
endmodule

// ----- rtl/ccst_ctrl.sv -----
// Controller: sequences one tick through normalize, classify, bins, clear, gates, want and publish.
module ccst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ccst_pkg::ccst_cmd_t cmd,
  input  ccst_pkg::ccst_sts_t sts,
  output logic                idx_clr,
  output logic                idx_inc,
  output logic [1:0]          mode
);
  import ccst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_CLASS, S_BIN, S_BSCAN, S_ESCAN, S_SHIFT,
    S_GATE, S_WANT, S_PUB
  } state_t;

  state_t state_r;
  logic [1:0] dsel_r, bsel_r;
  logic       in_end_r;   // removal belongs to end-clear search
  logic       out_valid_r;

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  // command decode
  always_comb begin
    cmd = '0;
    cmd.div_sel = dsel_r;
    cmd.bin_sel = bsel_r;
    idx_clr = 1'b0;
    idx_inc = 1'b0;
    mode = 2'd0;
    unique case (state_r)
      S_IDLE:  begin cmd.start = in_valid && !in_stall; end
      S_DIV:   begin cmd.div_start = 1'b1; end
      S_DIVW:  ;
      S_CLASS: begin cmd.classify = 1'b1; idx_clr = 1'b1; end
      S_BIN:   begin idx_clr = 1'b1; end
      S_BSCAN: begin
        mode = 2'd0;
        if (!sts.empty && sts.hit) begin
          cmd.scan_step = 1'b1;
          // a box moved on leaves the walk for the next bin
          if (!sts.match) idx_clr = 1'b1;
        end else if (!sts.empty && !sts.last) idx_inc = 1'b1;
        else idx_clr = 1'b1;
      end
      S_ESCAN: begin
        mode = 2'd1;
        if (!sts.empty && !sts.hit && !sts.last) idx_inc = 1'b1;
      end
      S_SHIFT: begin
        if (sts.last) begin cmd.shift_done = 1'b1; idx_clr = 1'b1; end
        else begin cmd.shift_step = 1'b1; idx_inc = 1'b1; end
      end
      S_GATE:  begin cmd.gate_tmo = 1'b1; cmd.want_clr = 1'b1; idx_clr = 1'b1; end
      S_WANT:  begin
        mode = 2'd2;
        if (!sts.empty) cmd.scan_step = 1'b1;
        if (!sts.empty && !sts.last) idx_inc = 1'b1;
      end
      // load the result register once the previous result has left
      S_PUB:   begin cmd.publish = !out_valid_r || !out_stall; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dsel_r <= '0;
      bsel_r <= '0;
      in_end_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_PUB && cmd.publish) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          dsel_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: if (!sts.div_busy) begin
          if (dsel_r == 2'd2) state_r <= S_CLASS;
          else begin dsel_r <= dsel_r + 2'd1; state_r <= S_DIV; end
        end
        S_CLASS: begin bsel_r <= '0; state_r <= S_BIN; end
        S_BIN: begin
          if (sts.bin_edge) state_r <= S_BSCAN;
          else if (bsel_r == 2'd2) state_r <= S_ESCAN;
          else bsel_r <= bsel_r + 2'd1;
        end
        S_BSCAN: begin
          if (!sts.empty && sts.hit && sts.match) begin
            in_end_r <= 1'b0;
            state_r <= S_SHIFT;
          end else if ((!sts.empty && sts.hit) || sts.empty || sts.last) begin
            state_r <= (bsel_r == 2'd2) ? S_ESCAN : S_BIN;
            if (bsel_r != 2'd2) bsel_r <= bsel_r + 2'd1;
          end
        end
        S_ESCAN: begin
          if (!sts.empty && sts.hit) begin in_end_r <= 1'b1; state_r <= S_SHIFT; end
          else if (sts.empty || sts.last) state_r <= S_GATE;
        end
        S_SHIFT: if (sts.last) begin
          if (in_end_r) state_r <= S_GATE;
          else if (bsel_r == 2'd2) state_r <= S_ESCAN;
          else begin bsel_r <= bsel_r + 2'd1; state_r <= S_BIN; end
        end
        S_GATE: state_r <= S_WANT;
        S_WANT: if (sts.empty || sts.last) state_r <= S_PUB;
        S_PUB: if (cmd.publish) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
